// File: hw/rtl/tkec_pkg.sv
// Shared types, codes and helpers for the touch key event classifier.
`timescale 1ns / 1ps

package tkec_pkg;

    localparam int KEY_COUNT = 5;
    localparam int KEY_W     = 5;

    // Configuration register indexes
    localparam logic [2:0] CFG_LONG_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_LONG_STEP       = 3'd1;
    localparam logic [2:0] CFG_HOLD_INTERVAL   = 3'd2;
    localparam logic [2:0] CFG_RELEASE_SAMPLES = 3'd3;
    localparam logic [2:0] CFG_DOUBLE_WINDOW   = 3'd4;

    localparam logic [15:0] RST_LONG_THRESHOLD  = 16'd1000;
    localparam logic [7:0]  RST_LONG_STEP       = 8'd11;
    localparam logic [15:0] RST_HOLD_INTERVAL   = 16'd150;
    localparam logic [15:0] RST_RELEASE_SAMPLES = 16'd50;
    localparam logic [7:0]  RST_DOUBLE_WINDOW   = 8'd200;

    // Classifier modes
    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_WINDOW     = 3'd1;
    localparam logic [2:0] MODE_HOLD       = 3'd2;
    localparam logic [2:0] MODE_WAIT_SHORT = 3'd3;
    localparam logic [2:0] MODE_WAIT_LONG  = 3'd4;

    // Event kinds
    localparam logic [2:0] EV_SHORT    = 3'd0;
    localparam logic [2:0] EV_DOUBLE   = 3'd1;
    localparam logic [2:0] EV_LONG     = 3'd2;
    localparam logic [2:0] EV_CONTINUE = 3'd3;
    localparam logic [2:0] EV_RELEASE  = 3'd4;

    localparam logic [16:0] TIME_MAX = 17'h1FFFF;
    localparam logic [15:0] RUN_MAX  = 16'hFFFF;
    localparam logic [7:0]  WIN_MAX  = 8'hFF;

    typedef struct packed {
        logic [15:0] long_threshold;
        logic [7:0]  long_step;
        logic [15:0] hold_interval;
        logic [15:0] release_samples;
        logic [7:0]  double_window;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [2:0] key_num;
    } evt_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } key_dec_t;

    // A word names a key only when exactly one bit below KEY_COUNT is set.
    function automatic key_dec_t key_decode(input logic [KEY_W-1:0] word);
        key_dec_t d;
        d.hit = 1'b0;
        d.idx = 3'd0;
        for (int i = 0; i < KEY_W; i++) begin
            if (i < KEY_COUNT && word == (KEY_W'(1) << i)) begin
                d.hit = 1'b1;
                d.idx = 3'(i);
            end
        end
        return d;
    endfunction

endpackage

// File: hw/rtl/tkec_cfg_regs.sv
// Configuration register bank of the touch key event classifier.
`timescale 1ns / 1ps

module tkec_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output tkec_pkg::cfg_t cfg
);
    import tkec_pkg::*;

    logic [15:0] long_threshold_reg;
    logic [7:0]  long_step_reg;
    logic [15:0] hold_interval_reg;
    logic [15:0] release_samples_reg;
    logic [7:0]  double_window_reg;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_threshold_reg  <= RST_LONG_THRESHOLD;
            long_step_reg       <= RST_LONG_STEP;
            hold_interval_reg   <= RST_HOLD_INTERVAL;
            release_samples_reg <= RST_RELEASE_SAMPLES;
            double_window_reg   <= RST_DOUBLE_WINDOW;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                CFG_LONG_THRESHOLD:  long_threshold_reg  <= cfg_data;
                CFG_LONG_STEP:       long_step_reg       <= cfg_data[7:0];
                CFG_HOLD_INTERVAL:   hold_interval_reg   <= cfg_data;
                CFG_RELEASE_SAMPLES: release_samples_reg <= cfg_data;
                CFG_DOUBLE_WINDOW:   double_window_reg   <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    assign cfg.long_threshold  = long_threshold_reg;
    assign cfg.long_step       = long_step_reg;
    assign cfg.hold_interval   = hold_interval_reg;
    assign cfg.release_samples = release_samples_reg;
    assign cfg.double_window   = double_window_reg;

endmodule

// File: hw/rtl/tkec_fsm.sv
// Press classification state and next-state logic, one sample per step.
`timescale 1ns / 1ps

module tkec_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [tkec_pkg::KEY_W-1:0]     key,
    input  tkec_pkg::cfg_t                 cfg,
    output tkec_pkg::evt_t                 evt
);
    import tkec_pkg::*;

    logic [2:0]       mode_reg,         mode_next;
    logic [KEY_W-1:0] held_key_reg,     held_key_next;
    logic [16:0]      press_time_reg,   press_time_next;
    logic [15:0]      zero_run_reg,     zero_run_next;
    logic [7:0]       window_count_reg, window_count_next;

    key_dec_t key_dec;
    key_dec_t held_dec;
    logic     ev_valid;
    logic     ev_on_key;
    logic [2:0] ev_kind;

    assign key_dec  = key_decode(key);
    assign held_dec = key_decode(held_key_reg);

    always_comb
    begin
        logic [17:0] sum;
        logic [16:0] press_add;
        logic [16:0] press_inc;
        logic [15:0] zr;
        logic [7:0]  win_inc;
        logic        rel_hit;
        logic        same;

        sum       = {1'b0, press_time_reg} + {10'd0, cfg.long_step};
        press_add = sum[17] ? TIME_MAX : sum[16:0];
        press_inc = (press_time_reg == TIME_MAX) ? TIME_MAX : press_time_reg + 17'd1;
        win_inc   = (window_count_reg == WIN_MAX) ? WIN_MAX : window_count_reg + 8'd1;
        // release counting: zero samples extend the run, any touch restarts it
        if (key == '0)
            zr = (zero_run_reg == RUN_MAX) ? RUN_MAX : zero_run_reg + 16'd1;
        else
            zr = 16'd0;
        rel_hit = zr >= cfg.release_samples;
        same    = key == held_key_reg;

        mode_next         = mode_reg;
        held_key_next     = held_key_reg;
        press_time_next   = press_time_reg;
        zero_run_next     = zero_run_reg;
        window_count_next = window_count_reg;
        ev_valid          = 1'b0;
        ev_on_key         = 1'b0;
        ev_kind           = EV_SHORT;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (held_key_reg == '0)
                    held_key_next = key;
                else if (same)
                begin
                    press_time_next = press_add;
                    if (press_add >= {1'b0, cfg.long_threshold})
                    begin
                        ev_valid        = key_dec.hit;
                        ev_on_key       = 1'b1;
                        ev_kind         = EV_LONG;
                        press_time_next = 17'd1;
                        mode_next       = MODE_HOLD;
                    end
                end
                else if (held_dec.hit)
                begin
                    mode_next         = MODE_WINDOW;
                    window_count_next = 8'd0;
                end
                else
                begin
                    mode_next       = MODE_IDLE;
                    held_key_next   = '0;
                    press_time_next = '0;
                end
            end
            MODE_WINDOW:
            begin
                window_count_next = win_inc;
                if (same || win_inc >= cfg.double_window)
                begin
                    ev_valid      = held_dec.hit;
                    ev_kind       = same ? EV_DOUBLE : EV_SHORT;
                    mode_next     = MODE_WAIT_SHORT;
                    zero_run_next = zr;
                    if (rel_hit)
                    begin
                        mode_next         = MODE_IDLE;
                        held_key_next     = '0;
                        press_time_next   = '0;
                        zero_run_next     = '0;
                        window_count_next = '0;
                    end
                end
            end
            MODE_HOLD:
            begin
                if (same)
                begin
                    press_time_next = press_inc;
                    if (key_dec.hit && press_inc >= {1'b0, cfg.hold_interval})
                    begin
                        press_time_next = '0;
                        ev_valid        = 1'b1;
                        ev_on_key       = 1'b1;
                        ev_kind         = EV_CONTINUE;
                    end
                end
                else
                begin
                    mode_next     = MODE_WAIT_LONG;
                    zero_run_next = zr;
                    if (rel_hit)
                    begin
                        ev_valid          = held_dec.hit;
                        ev_kind           = EV_RELEASE;
                        mode_next         = MODE_IDLE;
                        held_key_next     = '0;
                        press_time_next   = '0;
                        zero_run_next     = '0;
                        window_count_next = '0;
                    end
                end
            end
            MODE_WAIT_SHORT, MODE_WAIT_LONG:
            begin
                zero_run_next = zr;
                if (rel_hit)
                begin
                    ev_valid          = (mode_reg == MODE_WAIT_LONG) && held_dec.hit;
                    ev_kind           = EV_RELEASE;
                    mode_next         = MODE_IDLE;
                    held_key_next     = '0;
                    press_time_next   = '0;
                    zero_run_next     = '0;
                    window_count_next = '0;
                end
            end
            default:
            begin
                mode_next         = MODE_IDLE;
                held_key_next     = '0;
                press_time_next   = '0;
                zero_run_next     = '0;
                window_count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            held_key_reg     <= '0;
            press_time_reg   <= '0;
            zero_run_reg     <= '0;
            window_count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            held_key_reg     <= held_key_next;
            press_time_reg   <= press_time_next;
            zero_run_reg     <= zero_run_next;
            window_count_reg <= window_count_next;
        end
    end

    assign evt.valid   = step && ev_valid;
    assign evt.kind    = ev_kind;
    assign evt.key_num = ev_on_key ? key_dec.idx : held_dec.idx;

`ifndef SYNTH
    // The window is only opened for a recognized key.
    a_window_key: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_WINDOW |-> held_dec.hit)
        else $error("window open on unrecognized key");

    a_long_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.kind == EV_LONG |=> mode_reg == MODE_HOLD && press_time_reg == 17'd1)
        else $error("long event not followed by hold");

    a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(press_time_reg) && $stable(zero_run_reg))
        else $error("state moved without a step");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> zero_run_reg == '0 && window_count_reg == '0)
        else $error("idle with stale counters");
`endif

endmodule

// File: hw/rtl/touch_key_event_classifier_core.sv
// Top level of the touch key event classifier: channels, sample stage, result register.
`timescale 1ns / 1ps

// Touch key event classifier. Each transfer on the input channel is one scan
// tick carrying the key flag word; the block emits at most one event per tick
// (short, double click, long, continue, release after long) with the index of
// the key. It accepts one tick per clock cycle while in_stall is low: a tick is
// captured in a sample register and classified by the mode/counter logic, which
// loads its event, if any, into the result register when no result is held.
// A held result stalls only the sample stage; one more tick is still taken
// into an empty sample register.
// Configuration writes are always ready and must be issued while no tick is
// in flight.
module touch_key_event_classifier_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tkec_pkg::KEY_W-1:0] key_flags,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 event_kind,
    output logic [2:0]                 key_number,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [15:0]                cfg_data
);
    import tkec_pkg::*;

    cfg_t cfg;
    evt_t evt;

    logic             s1_valid_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic             out_valid_reg;
    logic [2:0]       event_kind_reg;
    logic [2:0]       key_number_reg;
    logic             out_blocked;
    logic             advance;
    logic             step;
    logic             accept;

    tkec_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkec_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .key   (s1_key_reg),
        .cfg   (cfg),
        .evt   (evt)
    );

    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = !out_blocked;
    assign step        = advance && s1_valid_reg;
    assign in_stall    = s1_valid_reg && out_blocked;
    assign accept      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_key_reg <= key_flags;
        if (evt.valid)
        begin
            event_kind_reg <= evt.kind;
            key_number_reg <= evt.key_num;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign key_number = key_number_reg;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the touch key event classifier: predictor, stimulus and event check.
`timescale 1ns / 1ps

module testbench;
    import tkec_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_TICKS    = 500;
    localparam int PHASE_TICKS     = 150;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 80;

    // index past the register list, must be ignored
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam logic [KEY_W-1:0] DIRECTED_TICKS [25] = '{
        5'd2, 5'd0, 5'd2, 5'd0, 5'd0,                        // double click
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd0,      // long, continues, release
        5'd3, 5'd0,                                          // unrecognized short press
        5'd31, 5'd31, 5'd31, 5'd0, 5'd0,                     // unrecognized long press
        5'd8, 5'd16, 5'd16, 5'd0, 5'd0                       // key change ends press, short
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] num;
    } key_event_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [KEY_W-1:0] key_flags = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [2:0]       event_kind;
    logic [2:0]       key_number;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = '0;
    logic [15:0]      cfg_data  = '0;

    // predictor copy of registers and classifier state
    cfg_t             regs;
    logic [2:0]       cls_mode;
    logic [KEY_W-1:0] cls_key;
    logic [16:0]      hold_time;
    logic [15:0]      zero_count;
    logic [7:0]       win_count;
    bit               tick_has_event;

    key_event_t pending_events[$];

    int fail_count    = 0;
    int ticks_sent    = 0;
    int events_seen   = 0;
    int settings_used = 1;
    bit burst_mode    = 1'b0;
    bit hold_off_req  = 1'b0;

    touch_key_event_classifier_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_flags  (key_flags),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .key_number (key_number),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    function automatic int key_slot(input logic [KEY_W-1:0] word);
        for (int i = 0; i < KEY_COUNT && i < KEY_W; i++)
        begin
            if (word == (KEY_W'(1) << i))
                return i;
        end
        return -1;
    endfunction

    function automatic void post_event(input logic [2:0] kind, input logic [KEY_W-1:0] word);
        int         k;
        key_event_t e;
        k = key_slot(word);
        if (k >= 0 && !tick_has_event)
        begin
            e.kind = kind;
            e.num  = 3'(k);
            pending_events.push_back(e);
            tick_has_event = 1'b1;
        end
    endfunction

    function automatic void clear_press();
        cls_mode   = MODE_IDLE;
        cls_key    = '0;
        hold_time  = '0;
        zero_count = '0;
        win_count  = '0;
    endfunction

    function automatic void track_release(input logic [KEY_W-1:0] word);
        if (word == '0)
        begin
            if (zero_count != RUN_MAX)
                zero_count++;
        end
        else
            zero_count = '0;
        if (zero_count >= regs.release_samples)
        begin
            if (cls_mode == MODE_WAIT_LONG)
                post_event(EV_RELEASE, cls_key);
            clear_press();
        end
    endfunction

    function automatic void classify_tick(input logic [KEY_W-1:0] word);
        logic [17:0] sum;
        tick_has_event = 1'b0;
        case (cls_mode)
            MODE_IDLE:
            begin
                if (cls_key == '0)
                    cls_key = word;
                else if (cls_key == word)
                begin
                    sum       = {1'b0, hold_time} + {10'd0, regs.long_step};
                    hold_time = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[16:0];
                    if (hold_time >= {1'b0, regs.long_threshold})
                    begin
                        post_event(EV_LONG, word);
                        hold_time = 17'd1;
                        cls_mode  = MODE_HOLD;
                    end
                end
                else if (key_slot(cls_key) >= 0)
                begin
                    cls_mode  = MODE_WINDOW;
                    win_count = '0;
                end
                else
                    clear_press();
            end
            MODE_WINDOW:
            begin
                if (win_count != WIN_MAX)
                    win_count++;
                if (word == cls_key)
                begin
                    post_event(EV_DOUBLE, cls_key);
                    cls_mode = MODE_WAIT_SHORT;
                end
                else if (win_count >= regs.double_window)
                begin
                    post_event(EV_SHORT, cls_key);
                    cls_mode = MODE_WAIT_SHORT;
                end
                // the resolving sample already counts toward release
                if (cls_mode == MODE_WAIT_SHORT)
                    track_release(word);
            end
            MODE_HOLD:
            begin
                if (word == cls_key)
                begin
                    if (hold_time != TIME_MAX)
                        hold_time++;
                    if (key_slot(word) >= 0 && hold_time >= {1'b0, regs.hold_interval})
                    begin
                        hold_time = '0;
                        post_event(EV_CONTINUE, word);
                    end
                end
                else
                begin
                    cls_mode = MODE_WAIT_LONG;
                    track_release(word);
                end
            end
            MODE_WAIT_SHORT, MODE_WAIT_LONG:
                track_release(word);
            default:
                clear_press();
        endcase
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_LONG_THRESHOLD:  regs.long_threshold  = data;
            CFG_LONG_STEP:       regs.long_step       = data[7:0];
            CFG_HOLD_INTERVAL:   regs.hold_interval   = data;
            CFG_RELEASE_SAMPLES: regs.release_samples = data;
            CFG_DOUBLE_WINDOW:   regs.double_window   = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic int idle_draw();
        if (burst_mode)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] w;
        if ($urandom_range(0, 9) != 0)
            return KEY_W'(1) << $urandom_range(0, KEY_COUNT - 1);
        do
            w = KEY_W'($urandom_range(3, 31));
        while (key_slot(w) >= 0);
        return w;
    endfunction

    function automatic cfg_t random_regs();
        cfg_t c;
        c.long_threshold  = 16'($urandom_range(1, 120));
        c.long_step       = 8'($urandom_range(1, 30));
        c.hold_interval   = 16'($urandom_range(2, 24));
        c.release_samples = 16'($urandom_range(1, 12));
        c.double_window   = 8'($urandom_range(1, 24));
        return c;
    endfunction

    // valid stays high between back-to-back transfers
    task automatic send_tick(input logic [KEY_W-1:0] word);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        key_flags <= word;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        classify_tick(word);
        ticks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input cfg_t c, input bit with_unused);
        logic [2:0]  idx [6];
        logic [15:0] val [6];
        int          n;
        idx[0] = CFG_LONG_THRESHOLD;  val[0] = c.long_threshold;
        idx[1] = CFG_LONG_STEP;       val[1] = {8'($urandom), c.long_step};
        idx[2] = CFG_HOLD_INTERVAL;   val[2] = c.hold_interval;
        idx[3] = CFG_RELEASE_SAMPLES; val[3] = c.release_samples;
        idx[4] = CFG_DOUBLE_WINDOW;   val[4] = {8'($urandom), c.double_window};
        idx[5] = CFG_UNUSED;          val[5] = 16'($urandom);
        n = with_unused ? 6 : 5;
        drain();
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            apply_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic release_tail(input int lead);
        repeat (lead) send_tick('0);
        if ($urandom_range(0, 4) == 0)
            send_tick(pick_key());    // bounce restarts the zero run
        repeat (int'(regs.release_samples) + $urandom_range(0, 2)) send_tick('0);
    endtask

    task automatic press_sequence();
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] second;
        int               to_long;
        int               hi;
        int               zeros;
        int               pick;
        to_long = 1 + (int'(regs.long_threshold) + int'(regs.long_step) - 1)
                      / int'(regs.long_step);
        key  = pick_key();
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            hi = to_long - 1;
            if (hi > 40)
                hi = 40;
            if (hi < 1)
                hi = 1;
            repeat ($urandom_range(1, hi)) send_tick(key);
            zeros = $urandom_range(1, int'(regs.double_window) + 2);
            repeat (zeros) send_tick('0);
            if ($urandom_range(0, 1) == 1)
            begin
                second = ($urandom_range(0, 3) == 0) ? pick_key() : key;
                repeat ($urandom_range(1, 4)) send_tick(second);
            end
            release_tail(int'(regs.double_window) + 1);
        end
        else if (pick < 75)
        begin
            repeat (to_long + int'(regs.hold_interval) * $urandom_range(0, 3)
                    + $urandom_range(0, int'(regs.hold_interval)))
                send_tick(key);
            release_tail(0);
        end
        else
            repeat ($urandom_range(1, 8)) send_tick(KEY_W'($urandom_range(0, 31)));
    endtask

    task automatic test_reset_values();
        repeat (3) send_tick(KEY_W'(1) << 1);
        repeat (int'(regs.double_window) + 2) send_tick('0);
        release_tail(0);
        send_tick(KEY_W'(1) << 2);
        send_tick('0);
        send_tick(KEY_W'(1) << 2);
        release_tail(0);
        repeat (250) send_tick(KEY_W'(1) << 4);
        release_tail(0);
    endtask

    task automatic test_directed();
        cfg_t c;
        c = '{long_threshold: 16'd2, long_step: 8'd1, hold_interval: 16'd2,
              release_samples: 16'd2, double_window: 8'd2};
        program_regs(c, 1'b1);
        foreach (DIRECTED_TICKS[i])
            send_tick(DIRECTED_TICKS[i]);
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        c = '{long_threshold: 16'd1, long_step: 8'd1, hold_interval: 16'd2,
              release_samples: 16'd1, double_window: 8'd1};
        program_regs(c, 1'b1);
        repeat (8) press_sequence();
        c = '{long_threshold: 16'hFFFF, long_step: 8'hFF, hold_interval: 16'hFFFF,
              release_samples: 16'hFFFF, double_window: 8'hFF};
        program_regs(c, 1'b0);
        repeat (260) send_tick(KEY_W'(1));
        send_tick('0);
        // release needs a zero run of RUN_MAX samples at this setting; lower it and finish the press
        c.release_samples = 16'd3;
        program_regs(c, 1'b1);
        repeat (3) send_tick('0);
        repeat (2) send_tick(KEY_W'(1) << 4);
        repeat (260) send_tick('0);
    endtask

    task automatic test_backpressure();
        cfg_t c;
        c = '{long_threshold: 16'd1, long_step: 8'd1, hold_interval: 16'd2,
              release_samples: 16'd4, double_window: 8'd4};
        program_regs(c, 1'b0);
        burst_mode   = 1'b1;
        hold_off_req = 1'b1;
        repeat (60) send_tick(KEY_W'(1) << 2);
        release_tail(0);
        burst_mode = 1'b0;
    endtask

    task automatic test_random();
        int start;
        int phase_start;
        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            program_regs(random_regs(), $urandom_range(0, 3) == 0);
            burst_mode  = ($urandom_range(0, 3) == 0);
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS)
                press_sequence();
            burst_mode = 1'b0;
        end
    endtask

    initial
    begin : event_check
        int         wait_cycles;
        key_event_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            wait_cycles  = hold_off_req ? HOLD_OFF_CYCLES : idle_draw();
            hold_off_req = 1'b0;
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            events_seen++;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: event_kind %0d key_number %0d",
                       event_kind, key_number);
                fail_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
                    fail_count++;
                end
                if (key_number !== want.num)
                begin
                    $error("key_number: expected %0d, actual %0d", want.num, key_number);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : main_seq
        regs = '{RST_LONG_THRESHOLD, RST_LONG_STEP, RST_HOLD_INTERVAL,
                 RST_RELEASE_SAMPLES, RST_DOUBLE_WINDOW};
        clear_press();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        drain();
        if (pending_events.size() != 0)
        begin
            $error("%0d expected events never arrived", pending_events.size());
            fail_count++;
        end
        $display("Sent %0d key ticks and checked %0d events across %0d register settings.",
                 ticks_sent, events_seen, settings_used);
        $display("Included range extremes, unrecognized words and a long output hold-off.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
